>>> hw/rtl/gfd_pkg.sv
package gfd_pkg;

  localparam int FRAME_BYTES = 9;

  // Frame byte positions
  localparam logic [3:0] POS_MODE    = 4'd1;
  localparam logic [3:0] POS_KEYS_LO = 4'd3;
  localparam logic [3:0] POS_KEYS_HI = 4'd4;
  localparam logic [3:0] POS_RX      = 4'd5;
  localparam logic [3:0] POS_RY      = 4'd6;
  localparam logic [3:0] POS_LX      = 4'd7;
  localparam logic [3:0] POS_LAST    = 4'(FRAME_BYTES - 1);

  // Mode byte ids and pad_mode codes
  localparam logic [7:0] ID_ANALOG  = 8'h73;
  localparam logic [7:0] ID_DIGITAL = 8'h41;

  localparam logic [1:0] MODE_ANALOG  = 2'd0;
  localparam logic [1:0] MODE_DIGITAL = 2'd1;
  localparam logic [1:0] MODE_LOST    = 2'd2;

  // Drive mapping constants
  localparam logic [11:0] SPEED_RESET  = 12'd1200;
  localparam logic [7:0]  STICK_CENTER = 8'd127;
  localparam logic [7:0]  DEAD_LO      = 8'd120;
  localparam logic [7:0]  DEAD_HI      = 8'd135;
  localparam logic [7:0]  RX_MIN       = 8'd20;
  localparam logic [7:0]  RX_MAX       = 8'd235;
  localparam logic [7:0]  ANGLE_CENTER = 8'd90;
  localparam logic [7:0]  ANGLE_FULL   = 8'd180;

  // x / 127 == (x * DIV127_MUL) >> DIV127_SHIFT, exact for x < 2^21
  localparam logic [20:0] DIV127_MUL   = 21'd1056833;
  localparam int          DIV127_SHIFT = 27;
  // y / 10 == (y * DIV10_MUL) >> DIV10_SHIFT, exact for y <= 900
  localparam logic [7:0]  DIV10_MUL    = 8'd205;
  localparam int          DIV10_SHIFT  = 11;

  localparam logic [12:0] SPEED_NEG_LIMIT = 13'h1000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] keys_raw;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } frame_rec_t;

endpackage

>>> hw/rtl/gfd_if.sv
interface gfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface gfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         pad_mode;
  logic [15:0]        keys_pressed;
  logic [4:0]         min_key_id;
  logic               new_key;
  logic               drive_valid;
  logic signed [12:0] speed_mm_s;
  logic [7:0]         front_deg;
  logic [7:0]         rear_angle;
  logic [7:0]         right_x;
  logic [7:0]         right_y;
  logic [7:0]         left_x;
  logic [7:0]         left_y;

  modport source (
    output valid, output pad_mode, output keys_pressed, output min_key_id,
    output new_key, output drive_valid, output speed_mm_s, output front_deg,
    output rear_angle, output right_x, output right_y, output left_x,
    output left_y, input ready
  );
  modport sink (
    input valid, input pad_mode, input keys_pressed, input min_key_id,
    input new_key, input drive_valid, input speed_mm_s, input front_deg,
    input rear_angle, input right_x, input right_y, input left_x,
    input left_y, output ready
  );
endinterface

interface gfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] max_speed_mm_s;

  modport source (output valid, output max_speed_mm_s, input ready);
  modport sink   (input valid, input max_speed_mm_s, output ready);
endinterface

>>> hw/rtl/gfd_front.sv
module gfd_front
  import gfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gfd_in_if.sink     in_ch,
  output logic       q_valid,
  input  logic       q_ready,
  output frame_rec_t q_data
);

  logic [3:0]  pos_r, pos_nxt;
  logic [3:0]  cur_pos;
  logic        is_last;
  logic        accept;
  logic [1:0]  mode_r;
  logic [15:0] keys_r;
  logic [7:0]  rx_r, ry_r, lx_r;

  // A start flag realigns the frame to byte 0
  assign cur_pos = in_ch.frame_start ? 4'd0 : pos_r;
  assign is_last = (cur_pos == POS_LAST);

  assign in_ch.ready = !is_last || q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_valid     = in_ch.valid && is_last;

  always_comb begin
    q_data.mode     = mode_r;
    q_data.keys_raw = keys_r;
    q_data.right_x  = rx_r;
    q_data.right_y  = ry_r;
    q_data.left_x   = lx_r;
    q_data.left_y   = in_ch.rx_byte;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = is_last ? 4'd0 : cur_pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Classify the mode byte as it arrives and capture the key and stick bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cur_pos == POS_MODE) begin
        if (in_ch.rx_byte == ID_ANALOG) begin
          mode_r <= MODE_ANALOG;
        end else if (in_ch.rx_byte == ID_DIGITAL) begin
          mode_r <= MODE_DIGITAL;
        end else begin
          mode_r <= MODE_LOST;
        end
      end
      if (cur_pos == POS_KEYS_LO) keys_r[7:0]  <= in_ch.rx_byte;
      if (cur_pos == POS_KEYS_HI) keys_r[15:8] <= in_ch.rx_byte;
      if (cur_pos == POS_RX)      rx_r         <= in_ch.rx_byte;
      if (cur_pos == POS_RY)      ry_r         <= in_ch.rx_byte;
      if (cur_pos == POS_LX)      lx_r         <= in_ch.rx_byte;
    end
  end

endmodule

>>> hw/rtl/gfd_queue.sv
module gfd_queue
  import gfd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  frame_rec_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output frame_rec_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_rec_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ready  = (cnt_r != CW'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

>>> hw/rtl/gfd_back.sv
module gfd_back
  import gfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  frame_rec_t q_data,
  gfd_cfg_if.sink    cfg_ch,
  gfd_out_if.source  out_ch
);

  function automatic logic [4:0] lowest_key(input logic [15:0] keys);
    logic [4:0] id;
    id = 5'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys[i]) id = 5'(i + 1);
    end
    return id;
  endfunction

  // v * 90 / 100 for v in 0..100
  function automatic logic [7:0] scale_angle(input logic [7:0] v);
    logic [9:0]  y;
    logic [17:0] p;
    y = 10'(v) * 10'd9;
    p = 18'(y) * 18'(DIV10_MUL);
    return {1'b0, p[DIV10_SHIFT +: 7]};
  endfunction

  function automatic logic [7:0] front_of(input logic [7:0] rx);
    logic [7:0] a;
    priority if (rx > DEAD_LO && rx < DEAD_HI) begin
      a = ANGLE_CENTER;
    end else if (rx < RX_MIN) begin
      a = 8'd0;
    end else if (rx <= DEAD_LO) begin
      a = scale_angle(rx - RX_MIN);
    end else if (rx > RX_MAX) begin
      a = ANGLE_FULL;
    end else begin
      a = ANGLE_CENTER + scale_angle(rx - DEAD_HI);
    end
    return a;
  endfunction

  logic [11:0] max_speed_r;
  logic [4:0]  prev_key_r;

  // Stage 1: key decode, angle, speed product
  logic        s1_valid_r;
  logic [1:0]  s1_mode_r;
  logic [15:0] s1_keys_r;
  logic [4:0]  s1_first_r;
  logic        s1_new_r;
  logic        s1_neg_r;
  logic [19:0] s1_mag_r;
  logic [7:0]  s1_front_r;
  logic [7:0]  s1_rx_r, s1_ry_r, s1_lx_r, s1_ly_r;

  // Stage 2: output register
  logic               o_valid_r;
  logic [1:0]         o_mode_r;
  logic [15:0]        o_keys_r;
  logic [4:0]         o_first_r;
  logic               o_new_r;
  logic               o_drive_r;
  logic signed [12:0] o_speed_r;
  logic [7:0]         o_front_r;
  logic [7:0]         o_rear_r;
  logic [7:0]         o_rx_r, o_ry_r, o_lx_r, o_ly_r;

  logic        s2_adv, s1_adv, s1_load;
  logic [15:0] keys;
  logic [4:0]  first;
  logic        analog;
  logic        neg;
  logic [7:0]  abs_d;
  logic [40:0] quot_prod;
  logic [12:0] quot;
  logic [12:0] speed;

  assign s2_adv  = !o_valid_r || out_ch.ready;
  assign s1_adv  = !s1_valid_r || s2_adv;
  assign q_ready = s1_adv;
  assign s1_load = q_valid && s1_adv;

  assign keys   = ~q_data.keys_raw;
  assign first  = lowest_key(keys);
  assign analog = (q_data.mode == MODE_ANALOG);
  assign neg    = (q_data.left_y > STICK_CENTER);
  assign abs_d  = neg ? q_data.left_y - STICK_CENTER : STICK_CENTER - q_data.left_y;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= SPEED_RESET;
    end else if (cfg_ch.valid) begin
      max_speed_r <= cfg_ch.max_speed_mm_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      prev_key_r <= 5'd0;
    end else begin
      if (s1_adv) s1_valid_r <= q_valid;
      if (s1_load) prev_key_r <= first;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_mode_r  <= q_data.mode;
      s1_keys_r  <= keys;
      s1_first_r <= first;
      s1_new_r   <= (first != 5'd0) && (first != prev_key_r);
      s1_neg_r   <= neg;
      s1_mag_r   <= 20'(abs_d) * 20'(max_speed_r);
      s1_front_r <= analog ? front_of(q_data.right_x) : ANGLE_CENTER;
      s1_rx_r    <= q_data.right_x;
      s1_ry_r    <= q_data.right_y;
      s1_lx_r    <= q_data.left_x;
      s1_ly_r    <= q_data.left_y;
    end
  end

  // Divide the magnitude by 127, then restore sign, saturating negative speeds; zero outside analog mode
  assign quot_prod = 41'(s1_mag_r) * 41'(DIV127_MUL);
  assign quot      = quot_prod[DIV127_SHIFT +: 13];

  always_comb begin
    if (s1_mode_r != MODE_ANALOG) begin
      speed = 13'd0;
    end else if (s1_neg_r) begin
      speed = (quot >= SPEED_NEG_LIMIT) ? SPEED_NEG_LIMIT : 13'(-quot);
    end else begin
      speed = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s2_adv) begin
      o_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_adv) begin
      o_mode_r  <= s1_mode_r;
      o_keys_r  <= s1_keys_r;
      o_first_r <= s1_first_r;
      o_new_r   <= s1_new_r;
      o_drive_r <= (s1_mode_r == MODE_ANALOG);
      o_speed_r <= signed'(speed);
      o_front_r <= s1_front_r;
      o_rear_r  <= ANGLE_FULL - s1_front_r;
      o_rx_r    <= s1_rx_r;
      o_ry_r    <= s1_ry_r;
      o_lx_r    <= s1_lx_r;
      o_ly_r    <= s1_ly_r;
    end
  end

  assign out_ch.valid        = o_valid_r;
  assign out_ch.pad_mode     = o_mode_r;
  assign out_ch.keys_pressed = o_keys_r;
  assign out_ch.min_key_id   = o_first_r;
  assign out_ch.new_key      = o_new_r;
  assign out_ch.drive_valid  = o_drive_r;
  assign out_ch.speed_mm_s   = o_speed_r;
  assign out_ch.front_deg    = o_front_r;
  assign out_ch.rear_angle   = o_rear_r;
  assign out_ch.right_x      = o_rx_r;
  assign out_ch.right_y      = o_ry_r;
  assign out_ch.left_x       = o_lx_r;
  assign out_ch.left_y       = o_ly_r;

endmodule

>>> hw/rtl/gamepad_frame_to_drive_unit.sv
// Gamepad poll-frame decoder. Takes one reply byte per clock on in_ch, with
// frame_start realigning to byte 0, and gives one result on out_ch for every
// ninth byte: mode, pressed keys, lowest key id, new-key flag, the four stick
// bytes and, in analog mode, speed in mm/s and front/rear servo angles. The
// byte port sustains one transaction per clock unless the queue is full at a
// frame's last byte. A result passes through the frame queue, decode/multiply
// stage and divide/output register. A frame queue of DEPTH entries lets the
// byte side keep running while results wait on out_ch. cfg_ch sets the
// full-deflection speed; write it only while no frame is in flight.
module gamepad_frame_to_drive_unit
  import gfd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  gfd_in_if.sink    in_ch,
  gfd_cfg_if.sink   cfg_ch,
  gfd_out_if.source out_ch
);

  logic       f_valid, f_ready;
  frame_rec_t f_data;
  logic       b_valid, b_ready;
  frame_rec_t b_data;

  gfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_data  (f_data)
  );

  gfd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  gfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_data  (b_data),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  a_drive_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive_valid == (out_ch.pad_mode == MODE_ANALOG)))
    else $error("drive_valid does not match pad_mode");

  a_idle_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.drive_valid) |->
      (out_ch.speed_mm_s == 13'sd0 && out_ch.front_deg == ANGLE_CENTER))
    else $error("drive fields not centered outside analog mode");

  a_angles: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (9'(out_ch.front_deg) + 9'(out_ch.rear_angle) == 9'(ANGLE_FULL)))
    else $error("front and rear angles do not sum to full range");

  a_min_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.min_key_id == 5'd0) == (out_ch.keys_pressed == 16'd0)
                      && (!out_ch.new_key || out_ch.min_key_id != 5'd0)))
    else $error("min_key_id inconsistent with keys_pressed");

  a_frame_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && f_ready) |=> b_valid)
    else $error("accepted frame not visible at queue output");
`endif

endmodule
